// ===== rtl/aes_pkg.sv =====
// shared types, constants and round functions for the aes-128 block
package aes_pkg;

	localparam int unsigned NumRounds = 10;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_KEY_HIGH = 2'd0,
		CFG_KEY_LOW  = 2'd1,
		CFG_MODE     = 2'd2,
		CFG_UNUSED   = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [63:0] block_high;
		logic [63:0] block_low;
	} in_item_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} out_item_t;

	typedef logic [127:0] state_t;
	typedef state_t [NumRounds:0] round_keys_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	localparam logic [7:0] RCON [NumRounds] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	// byte i of the block sits at bits 127-8i
	function automatic logic [7:0] get_byte(state_t s, int i);
		return s[127-8*i -: 8];
	endfunction

	function automatic logic [7:0] xtime(logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic state_t sub_bytes(state_t s, logic inv);
		state_t t;
		for (int i = 0; i < 16; i++) begin
			t[127-8*i -: 8] = inv ? INV_SBOX[get_byte(s, i)] : SBOX[get_byte(s, i)];
		end
		return t;
	endfunction

	function automatic state_t shift_rows(state_t s, logic inv);
		state_t t;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (inv) begin
					t[127-8*(r+4*((c+r)&3)) -: 8] = get_byte(s, r+4*c);
				end else begin
					t[127-8*(r+4*c) -: 8] = get_byte(s, r+4*((c+r)&3));
				end
			end
		end
		return t;
	endfunction

	function automatic state_t mix_columns(state_t s, logic inv);
		state_t t;
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] m2 [4];
		logic [7:0] m3 [4];
		logic [7:0] m9 [4];
		logic [7:0] mb [4];
		logic [7:0] md [4];
		logic [7:0] me [4];
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				a[r] = get_byte(s, r+4*c);
				x2[r] = xtime(a[r]);
				x4[r] = xtime(x2[r]);
				x8[r] = xtime(x4[r]);
				m2[r] = x2[r];
				m3[r] = x2[r] ^ a[r];
				m9[r] = x8[r] ^ a[r];
				mb[r] = x8[r] ^ x2[r] ^ a[r];
				md[r] = x8[r] ^ x4[r] ^ a[r];
				me[r] = x8[r] ^ x4[r] ^ x2[r];
			end
			for (int r = 0; r < 4; r++) begin
				if (inv) begin
					t[127-8*(r+4*c) -: 8] = me[r] ^ mb[(r+1)&3] ^ md[(r+2)&3] ^ m9[(r+3)&3];
				end else begin
					t[127-8*(r+4*c) -: 8] = m2[r] ^ m3[(r+1)&3] ^ a[(r+2)&3] ^ a[(r+3)&3];
				end
			end
		end
		return t;
	endfunction

endpackage

// ===== rtl/aes_key_sched.sv =====
// key schedule: expands the configured key into all round keys, one round key per cycle
module aes_key_sched (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 restart,
	input  logic [127:0]         key,
	output logic                 busy,
	output aes_pkg::round_keys_t round_keys
);

	localparam int unsigned Nr = aes_pkg::NumRounds;

	logic [3:0]      step_q;
	logic [7:0]      rcon_q;
	aes_pkg::state_t work_q;
	aes_pkg::state_t next_key;

	// step 0 loads the key, steps 1 to 10 build one round key each
	assign busy = (step_q <= 4'(Nr));

	// one key schedule round on the previous round key
	always_comb begin
		logic [31:0] w [4];
		logic [31:0] t;
		for (int c = 0; c < 4; c++) begin
			w[c] = work_q[127-32*c -: 32];
		end
		t = {aes_pkg::SBOX[w[3][23:16]], aes_pkg::SBOX[w[3][15:8]],
			aes_pkg::SBOX[w[3][7:0]], aes_pkg::SBOX[w[3][31:24]]}
			^ {rcon_q, 24'h0};
		w[0] = w[0] ^ t;
		w[1] = w[1] ^ w[0];
		w[2] = w[2] ^ w[1];
		w[3] = w[3] ^ w[2];
		next_key = {w[0], w[1], w[2], w[3]};
	end

	// expansion walk, restarted by every key write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= '0;
			rcon_q     <= 8'h01;
			work_q     <= '0;
			round_keys <= '0;
		end else if (restart) begin
			step_q <= '0;
		end else if (busy) begin
			if (step_q == 4'd0) begin
				work_q        <= key;
				round_keys[0] <= key;
				rcon_q        <= 8'h01;
			end else begin
				work_q             <= next_key;
				round_keys[step_q] <= next_key;
				rcon_q             <= aes_pkg::xtime(rcon_q);
			end
			step_q <= step_q + 4'd1;
		end
	end

endmodule

// ===== rtl/aes_round.sv =====
// one pipelined cipher round, encrypt or decrypt
module aes_round (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic            valid_in,
	input  aes_pkg::state_t state_in,
	input  aes_pkg::state_t round_key,
	input  logic            decrypt,
	input  logic            last,
	output logic            valid_s1,
	output aes_pkg::state_t state_s1
);

	aes_pkg::state_t sr;
	aes_pkg::state_t sb;
	aes_pkg::state_t mc;
	aes_pkg::state_t nxt;

	// encrypt: sub, shift, mix, key; decrypt: shift, sub, key, mix; the last round skips mix
	always_comb begin
		sr = aes_pkg::shift_rows(state_in, decrypt);
		sb = aes_pkg::sub_bytes(decrypt ? state_in : sr, decrypt);
		if (decrypt) begin
			sb = aes_pkg::sub_bytes(sr, 1'b1) ^ round_key;
			mc = aes_pkg::mix_columns(sb, 1'b1);
			nxt = last ? sb : mc;
		end else begin
			sb = aes_pkg::shift_rows(aes_pkg::sub_bytes(state_in, 1'b0), 1'b0);
			mc = aes_pkg::mix_columns(sb, 1'b0);
			nxt = (last ? sb : mc) ^ round_key;
		end
	end

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			state_s1 <= nxt;
		end
	end

endmodule

// ===== rtl/aes128_block_cipher.sv =====
// aes-128 block cipher top level, ten-stage round pipeline
//
// channel | direction | handshake          | payload
// in      | in        | in_valid/in_stall  | in_data (aes_pkg::in_item_t)
// out     | out       | out_valid/out_stall| out_data (aes_pkg::out_item_t)
// cfg     | in        | cfg_we             | cfg_index, cfg_data
//
// one block per cycle unless stalled; path is key add stage then ten round stages
// round keys are built one per cycle after reset or a key write; input stalls while they are built
// an output stall freezes the whole pipeline, empty stages included
// reset clears key, mode and all stage valid bits
module aes128_block_cipher (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  aes_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output aes_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	localparam int unsigned Nr = aes_pkg::NumRounds;

	logic [63:0] key_high_q;
	logic [63:0] key_low_q;
	logic        mode_q;
	aes_pkg::round_keys_t rk;
	logic        key_restart;
	logic        key_busy;

	logic             v [Nr+1];
	aes_pkg::state_t  s [Nr+1];
	logic             advance;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			mode_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (aes_pkg::cfg_index_t'(cfg_index))
				aes_pkg::CFG_KEY_HIGH: key_high_q <= cfg_data;
				aes_pkg::CFG_KEY_LOW:  key_low_q  <= cfg_data;
				aes_pkg::CFG_MODE:     mode_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// a key write starts a new expansion
	assign key_restart = cfg_we &&
		(aes_pkg::cfg_index_t'(cfg_index) == aes_pkg::CFG_KEY_HIGH ||
		aes_pkg::cfg_index_t'(cfg_index) == aes_pkg::CFG_KEY_LOW);

	aes_key_sched u_key (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (key_restart),
		.key        ({key_high_q, key_low_q}),
		.busy       (key_busy),
		.round_keys (rk)
	);

	// global advance: move when output is free or not holding a transfer
	assign advance  = !(v[Nr] && out_stall);
	assign in_stall = !advance || key_busy;

	// initial key add stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v[0] <= 1'b0;
		end else if (advance) begin
			v[0] <= in_valid && !key_busy;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			s[0] <= {in_data.block_high, in_data.block_low} ^ (mode_q ? rk[Nr] : rk[0]);
		end
	end

	// round stages
	for (genvar n = 1; n <= Nr; n++) begin : g_round
		aes_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.valid_in  (v[n-1]),
			.state_in  (s[n-1]),
			.round_key (mode_q ? rk[Nr-n] : rk[n]),
			.decrypt   (mode_q),
			.last      (n == Nr),
			.valid_s1  (v[n]),
			.state_s1  (s[n])
		);
	end

	assign out_valid = v[Nr];
	assign out_data  = aes_pkg::out_item_t'(s[Nr]);

endmodule

// ===== rtl/aes_checker.sv =====
// port-level checks for the aes-128 block, bound to the top level
module aes_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input aes_pkg::out_item_t out_data
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// a held-back result stalls the input
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input open while result held back");

	// key expansion after reset keeps the input stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> in_stall)
		else $error("input open right after reset");

	// an offered block stays offered until its transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("offered block withdrawn");

	// no result right after reset
	assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result right after reset");

endmodule

bind aes128_block_cipher aes_checker u_aes_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
